/* rtl/wps_pkg.sv */
package wps_pkg;

  localparam int unsigned NUM_W  = 35;            // widest dividend (km/h numerator)
  localparam int unsigned DEN_W  = 36;            // widest divisor (ten times dt)
  localparam int unsigned QUO_W  = 16;            // quotient bits, saturating
  localparam int unsigned DSH_W  = DEN_W + QUO_W - 1;
  localparam int unsigned PWR_W  = 7;
  localparam int unsigned PNUM_W = 17;            // voltage times 100

  localparam logic [7:0]  MM_PER_PULSE_RST = 8'd49;
  localparam logic [15:0] KMH_SCALE_RST    = 16'd792;
  localparam logic [15:0] SPEED_MIN_RST    = 16'd1000;
  localparam logic [6:0]  POWER_MIN_RST    = 7'd100;
  localparam logic [15:0] SPEED_SAT        = 16'hFFFF;

  // Register word index taken from paddr[2].
  localparam logic REG_MM_PER_PULSE = 1'b0;
  localparam logic REG_KMH_SCALE    = 1'b1;

  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_LOAD_MM,
    S_DIV_MM,
    S_LOAD_KMH,
    S_DIV_KMH,
    S_DONE
  } state_t;

endpackage

/* rtl/wheel_pulse_speed_statistics.sv */
// Start word: goes straight to S_DONE. Only S_IDLE accepts a word, so words never overlap.
// Sample word: S_PREP, S_MUL, S_LOAD_MM, S_DIV_MM, S_LOAD_KMH, S_DIV_KMH, then S_DONE.
// One shared radix-2 divider runs 16 quotient steps for mm/s
// and then 16 for km/h; the power quotient runs alongside in 7 steps.
// A waiting result holds the block in its final state until the output register is free.
// rst_n is synchronous, active low: it resets control, totals, statistics and config registers.
module wheel_pulse_speed_statistics (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_pulse_count,
  input  logic [31:0] in_time_ms,
  input  logic [9:0]  in_voltage_raw,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_total_pulses,
  output logic [31:0] out_total_distance_mm,
  output logic [15:0] out_speed_mm_per_s,
  output logic [15:0] out_speed_kmh,
  output logic [6:0]  out_power_percent,
  output logic [15:0] out_avg_speed_kmh,
  output logic [15:0] out_max_speed_kmh,
  output logic [15:0] out_min_speed_kmh,
  output logic [6:0]  out_max_power_percent,
  output logic [6:0]  out_min_power_percent
);

  wps_pkg::state_t state_r, state_nxt;

  logic [7:0]  mm_per_pulse_r;
  logic [15:0] kmh_scale_r;

  logic [31:0] ref_time_r;
  logic [31:0] dist_total_r;
  logic [31:0] pulse_total_r;
  logic [15:0] avg_r;
  logic [15:0] max_spd_r;
  logic [15:0] min_spd_r;
  logic [6:0]  max_pwr_r;
  logic [6:0]  min_pwr_r;

  logic        action_r;
  logic [7:0]  pulses_r;
  logic [31:0] now_r;
  logic [9:0]  volt_r;
  logic [15:0] d_r;
  logic [31:0] dt_r;
  logic [31:0] prod_r;
  logic [wps_pkg::NUM_W-1:0] nkmh_r;
  logic [15:0] spd_mm_r;

  logic [wps_pkg::NUM_W-1:0] rem_r;
  logic [wps_pkg::DSH_W-1:0] dsh_r;
  logic [wps_pkg::QUO_W-1:0] q_r;
  logic        sat_r;
  logic [3:0]  cnt_r;

  logic [wps_pkg::PNUM_W-1:0] pw_rem_r;
  logic [wps_pkg::PNUM_W-1:0] pw_dsh_r;
  logic [wps_pkg::PWR_W-1:0]  pw_q_r;

  logic        out_valid_r;
  logic [31:0] o_pulses_r, o_dist_r;
  logic [15:0] o_spd_mm_r, o_spd_kmh_r, o_avg_r, o_max_spd_r, o_min_spd_r;
  logic [6:0]  o_pwr_r, o_max_pwr_r, o_min_pwr_r;

  logic        cfg_wr;
  logic        in_acc;
  logic        out_free;
  logic        div_load;
  logic [wps_pkg::NUM_W-1:0] div_n;
  logic [wps_pkg::DEN_W-1:0] div_d;
  logic        div_ge;
  logic        pw_ge;
  logic [15:0] spd_kmh;
  logic [16:0] avg_sum;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = (state_r == wps_pkg::S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      wps_pkg::REG_MM_PER_PULSE: prdata = {24'd0, mm_per_pulse_r};
      wps_pkg::REG_KMH_SCALE:    prdata = {16'd0, kmh_scale_r};
      default:                   prdata = '0;
    endcase
  end

  // Divider operands: first the mm/s quotient, then the km/h quotient.
  always_comb begin
    div_load = 1'b0;
    div_n    = '0;
    div_d    = '0;
    if (state_r == wps_pkg::S_LOAD_MM) begin
      div_load = 1'b1;
      div_n    = wps_pkg::NUM_W'(d_r) * wps_pkg::NUM_W'(1000);
      div_d    = wps_pkg::DEN_W'(dt_r);
    end else if (state_r == wps_pkg::S_LOAD_KMH) begin
      div_load = 1'b1;
      div_n    = nkmh_r;
      div_d    = (wps_pkg::DEN_W'(dt_r) << 3) + (wps_pkg::DEN_W'(dt_r) << 1);
    end
  end

  assign div_ge  = {16'd0, rem_r} >= dsh_r;
  assign pw_ge   = pw_rem_r >= pw_dsh_r;
  assign spd_kmh = sat_r ? wps_pkg::SPEED_SAT : q_r;
  assign avg_sum = {1'b0, avg_r} + {1'b0, spd_kmh};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wps_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_action == wps_pkg::ACT_START) ? wps_pkg::S_DONE : wps_pkg::S_PREP;
        end
      end
      wps_pkg::S_PREP:     state_nxt = wps_pkg::S_MUL;
      wps_pkg::S_MUL:      state_nxt = wps_pkg::S_LOAD_MM;
      wps_pkg::S_LOAD_MM:  state_nxt = wps_pkg::S_DIV_MM;
      wps_pkg::S_DIV_MM: begin
        if (cnt_r == 4'd0) state_nxt = wps_pkg::S_LOAD_KMH;
      end
      wps_pkg::S_LOAD_KMH: state_nxt = wps_pkg::S_DIV_KMH;
      wps_pkg::S_DIV_KMH: begin
        if (cnt_r == 4'd0) state_nxt = wps_pkg::S_DONE;
      end
      wps_pkg::S_DONE: begin
        if (out_free) state_nxt = wps_pkg::S_IDLE;
      end
      default:             state_nxt = wps_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wps_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_per_pulse_r <= wps_pkg::MM_PER_PULSE_RST;
      kmh_scale_r    <= wps_pkg::KMH_SCALE_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        wps_pkg::REG_MM_PER_PULSE: mm_per_pulse_r <= pwdata[7:0];
        wps_pkg::REG_KMH_SCALE:    kmh_scale_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Operand path and serial dividers; these registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_r <= in_action;
      pulses_r <= in_pulse_count;
      now_r    <= in_time_ms;
      volt_r   <= in_voltage_raw;
    end
    if (state_r == wps_pkg::S_PREP) begin
      d_r      <= 16'(pulses_r) * 16'(mm_per_pulse_r);
      dt_r     <= now_r - ref_time_r;
      pw_rem_r <= wps_pkg::PNUM_W'(volt_r) * wps_pkg::PNUM_W'(100);
      pw_dsh_r <= wps_pkg::PNUM_W'(1023) << (wps_pkg::PWR_W - 1);
      pw_q_r   <= '0;
    end
    if (state_r == wps_pkg::S_MUL) begin
      prod_r <= 32'(d_r) * 32'(kmh_scale_r);
    end
    if (state_r == wps_pkg::S_LOAD_MM) begin
      nkmh_r <= wps_pkg::NUM_W'(prod_r) + (wps_pkg::NUM_W'(dt_r) << 2) + wps_pkg::NUM_W'(dt_r);
    end
    if (state_r == wps_pkg::S_LOAD_KMH) begin
      spd_mm_r <= sat_r ? wps_pkg::SPEED_SAT : q_r;
    end
    if (div_load) begin
      // A quotient of 2^16 or more saturates; a zero divisor always lands here.
      rem_r <= div_n;
      dsh_r <= {div_d, {(wps_pkg::QUO_W-1){1'b0}}};
      sat_r <= {17'd0, div_n} >= {div_d, {wps_pkg::QUO_W{1'b0}}};
      q_r   <= '0;
      cnt_r <= 4'(wps_pkg::QUO_W - 1);
    end else if (state_r == wps_pkg::S_DIV_MM || state_r == wps_pkg::S_DIV_KMH) begin
      if (div_ge) rem_r <= rem_r - dsh_r[wps_pkg::NUM_W-1:0];
      q_r   <= {q_r[wps_pkg::QUO_W-2:0], div_ge};
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r - 4'd1;
    end
    // The power quotient is below 128, so seven steps during the first divide suffice.
    if (state_r == wps_pkg::S_DIV_MM && cnt_r >= 4'd9) begin
      if (pw_ge) pw_rem_r <= pw_rem_r - pw_dsh_r;
      pw_q_r   <= {pw_q_r[wps_pkg::PWR_W-2:0], pw_ge};
      pw_dsh_r <= pw_dsh_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_time_r    <= '0;
      dist_total_r  <= '0;
      pulse_total_r <= '0;
      avg_r         <= '0;
      max_spd_r     <= '0;
      min_spd_r     <= wps_pkg::SPEED_MIN_RST;
      max_pwr_r     <= '0;
      min_pwr_r     <= wps_pkg::POWER_MIN_RST;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == wps_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
        ref_time_r  <= now_r;
        o_avg_r     <= avg_r;
        o_max_spd_r <= max_spd_r;
        o_min_spd_r <= min_spd_r;
        o_max_pwr_r <= max_pwr_r;
        o_min_pwr_r <= min_pwr_r;
        if (action_r == wps_pkg::ACT_START) begin
          dist_total_r  <= '0;
          pulse_total_r <= '0;
          o_pulses_r    <= '0;
          o_dist_r      <= '0;
          o_spd_mm_r    <= '0;
          o_spd_kmh_r   <= '0;
          o_pwr_r       <= '0;
        end else begin
          dist_total_r  <= dist_total_r + 32'(d_r);
          pulse_total_r <= pulse_total_r + 32'(pulses_r);
          avg_r         <= avg_sum[16:1];
          o_pulses_r    <= pulse_total_r + 32'(pulses_r);
          o_dist_r      <= dist_total_r + 32'(d_r);
          o_spd_mm_r    <= spd_mm_r;
          o_spd_kmh_r   <= spd_kmh;
          o_pwr_r       <= pw_q_r;
          o_avg_r       <= avg_sum[16:1];
          if (spd_kmh > max_spd_r) begin
            max_spd_r   <= spd_kmh;
            o_max_spd_r <= spd_kmh;
          end
          if (spd_kmh < min_spd_r) begin
            min_spd_r   <= spd_kmh;
            o_min_spd_r <= spd_kmh;
          end
          if (pw_q_r > max_pwr_r) begin
            max_pwr_r   <= pw_q_r;
            o_max_pwr_r <= pw_q_r;
          end
          if (pw_q_r < min_pwr_r) begin
            min_pwr_r   <= pw_q_r;
            o_min_pwr_r <= pw_q_r;
          end
        end
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_total_pulses      = o_pulses_r;
  assign out_total_distance_mm = o_dist_r;
  assign out_speed_mm_per_s    = o_spd_mm_r;
  assign out_speed_kmh         = o_spd_kmh_r;
  assign out_power_percent     = o_pwr_r;
  assign out_avg_speed_kmh     = o_avg_r;
  assign out_max_speed_kmh     = o_max_spd_r;
  assign out_min_speed_kmh     = o_min_spd_r;
  assign out_max_power_percent = o_max_pwr_r;
  assign out_min_power_percent = o_min_pwr_r;

`ifndef NO_ASSERTIONS
  a_avg_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    avg_r <= max_spd_r)
    else $error("running average exceeds maximum speed");

  a_pwr_range: assert property (@(posedge clk) disable iff (!rst_n)
    max_pwr_r <= 7'd100 && min_pwr_r <= 7'd100)
    else $error("power statistic above 100 percent");

  a_zero_dt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wps_pkg::S_DIV_MM && dt_r == 32'd0) |-> sat_r)
    else $error("zero interval did not saturate");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wps_pkg::S_DIV_KMH && state_nxt == wps_pkg::S_DONE) |-> cnt_r == 4'd0)
    else $error("divider left before all quotient steps");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("second word accepted while one is in progress");
`endif

endmodule
